### sv/joint_impedance_torque_assert.svh
`ifndef JOINT_IMPEDANCE_TORQUE_ASSERT_SVH
`define JOINT_IMPEDANCE_TORQUE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define JIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define JIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/jit_pkg.sv
`timescale 1ns / 1ps
package jit_pkg;

  localparam int JOINTS_PER_ARM = 7;
  localparam int ARM_COUNT = 2;
  localparam int TABLE_DEPTH = JOINTS_PER_ARM * ARM_COUNT;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET = 17'd64881;
  localparam logic [23:0] STIFF_RESET = 24'd12800;
  localparam logic [23:0] DAMP_RESET = 24'd1280;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_DESIRED = 2'd1,
    ACT_GAINS   = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_FILT,
    ST_MUL2,
    ST_TRQ
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               arm;
    logic [2:0]         joint;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [23:0]        stiffness;
    logic [23:0]        damping;
  } in_item_t;

  typedef struct packed {
    logic               out_arm;
    logic [2:0]         out_joint;
    logic signed [31:0] torque;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] desired;
    logic signed [31:0] fvel;
    logic [23:0]        stiff;
    logic [23:0]        damp;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    desired: 32'sd0,
    fvel:    32'sd0,
    stiff:   STIFF_RESET,
    damp:    DAMP_RESET
  };

  typedef struct packed {
    logic    cap;
    logic    mul1;
    logic    filt;
    logic    mul2;
    logic    trq;
    logic    wr;
    action_t act;
  } ctrl_t;

  function automatic logic item_ok(input logic [1:0] action, input logic arm,
                                   input logic [2:0] joint);
    return (int'(arm) < ARM_COUNT) && (int'(joint) < JOINTS_PER_ARM) &&
           (action != ACT_NONE);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_index(input logic arm, input logic [2:0] joint);
    return ADDR_W'(int'(arm) * JOINTS_PER_ARM + int'(joint));
  endfunction

endpackage

### sv/jit_state_mem.sv
`timescale 1ns / 1ps
module jit_state_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [jit_pkg::ADDR_W-1:0] rd_addr,
  output jit_pkg::entry_t            rd_data,
  input  logic                       wr_en,
  input  logic [jit_pkg::ADDR_W-1:0] wr_addr,
  input  jit_pkg::entry_t            wr_data
);
  import jit_pkg::*;

  entry_t                 mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  entry_t                 rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : ENTRY_RESET;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/jit_ctrl.sv
`timescale 1ns / 1ps
module jit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  jit_pkg::in_item_t in_item,
  output logic              busy,
  output jit_pkg::ctrl_t    ctrl
);
  import jit_pkg::*;

  state_t  state_r, state_nxt;
  action_t act_r;
  logic    accept;

  assign accept = (state_r == ST_IDLE) && start &&
                  item_ok(in_item.action, in_item.arm, in_item.joint);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= ACT_SAMPLE;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        act_r <= action_t'(in_item.action);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        state_nxt = (act_r == ACT_SAMPLE) ? ST_FILT : ST_IDLE;
      end
      ST_FILT: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        state_nxt = ST_TRQ;
      end
      ST_TRQ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    ctrl.cap  = accept;
    ctrl.mul1 = (state_r == ST_MUL1);
    ctrl.filt = (state_r == ST_FILT);
    ctrl.mul2 = (state_r == ST_MUL2);
    ctrl.trq  = (state_r == ST_TRQ);
    ctrl.wr   = ((state_r == ST_MUL1) && (act_r != ACT_SAMPLE)) || (state_r == ST_FILT);
    ctrl.act  = act_r;
  end

endmodule

### sv/jit_dpath.sv
`timescale 1ns / 1ps
module jit_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jit_pkg::ctrl_t             ctrl,
  input  jit_pkg::in_item_t          in_item,
  input  logic                       cfg_we,
  input  logic [16:0]                cfg_wdata,
  input  jit_pkg::entry_t            rd_data,
  output logic [jit_pkg::ADDR_W-1:0] rd_addr,
  output logic [jit_pkg::ADDR_W-1:0] wr_addr,
  output jit_pkg::entry_t            wr_data,
  output logic                       out_valid,
  output jit_pkg::out_item_t         out_item
);
  import jit_pkg::*;

  logic [16:0]        weight_r;
  in_item_t           item_r;
  entry_t             ent_r;
  logic signed [49:0] pf_old_r, pf_new_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] nf_r;
  logic signed [57:0] pt_stiff_r;
  logic signed [56:0] pt_damp_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [16:0]        w_eff;
  logic signed [17:0] w_old_s, w_new_s;
  logic signed [49:0] pf_old, pf_new;
  logic signed [32:0] diff;
  logic signed [50:0] filt_sum;
  logic signed [31:0] nf;
  logic signed [24:0] stiff_s, damp_s;
  logic signed [58:0] acc;
  logic signed [42:0] tq;
  logic               sat_hi, sat_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_we) begin
      weight_r <= cfg_wdata;
    end
  end

  assign w_eff   = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_old_s = $signed({1'b0, w_eff});
  assign w_new_s = $signed({1'b0, WEIGHT_ONE - w_eff});
  assign pf_old  = w_old_s * rd_data.fvel;
  assign pf_new  = w_new_s * item_r.velocity;
  assign diff    = 33'(rd_data.desired) - 33'(item_r.position);

  assign filt_sum = 51'(pf_old_r) + 51'(pf_new_r) + 51'sd32768;
  assign nf       = filt_sum[47:16];

  assign stiff_s = $signed({1'b0, ent_r.stiff});
  assign damp_s  = $signed({1'b0, ent_r.damp});

  assign acc    = 59'(pt_stiff_r) - 59'(pt_damp_r) + 59'sd32768;
  assign tq     = acc[58:16];
  assign sat_hi = !tq[42] && (|tq[41:31]);
  assign sat_lo = tq[42] && !(&tq[41:31]);

  assign rd_addr = entry_index(in_item.arm, in_item.joint);
  assign wr_addr = entry_index(item_r.arm, item_r.joint);

  always_comb begin
    wr_data = rd_data;
    priority if (ctrl.filt) begin
      wr_data      = ent_r;
      wr_data.fvel = nf;
    end else if (ctrl.act == ACT_DESIRED) begin
      wr_data.desired = item_r.position;
    end else begin
      wr_data.stiff = item_r.stiffness;
      wr_data.damp  = item_r.damping;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      item_r <= in_item;
    end
    if (ctrl.mul1) begin
      ent_r    <= rd_data;
      pf_old_r <= pf_old;
      pf_new_r <= pf_new;
      diff_r   <= diff;
    end
    if (ctrl.filt) begin
      nf_r <= nf;
    end
    if (ctrl.mul2) begin
      pt_stiff_r <= stiff_s * diff_r;
      pt_damp_r  <= damp_s * nf_r;
    end
    if (ctrl.trq) begin
      out_item_r.out_arm   <= item_r.arm;
      out_item_r.out_joint <= item_r.joint;
      out_item_r.saturated <= sat_hi || sat_lo;
      priority if (sat_hi) begin
        out_item_r.torque <= 32'sh7fffffff;
      end else if (sat_lo) begin
        out_item_r.torque <= 32'sh80000000;
      end else begin
        out_item_r.torque <= tq[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.trq;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/joint_impedance_torque.sv
`timescale 1ns / 1ps
// Per-joint impedance torque for two arms of seven joints each.
// Input: an item transfers at a rising edge where start is high and busy is low.
// Items with a joint, arm or action that is out of range are taken and dropped
// in that same cycle. A set-desired or load-gains item keeps busy high in state
// MUL1 while its table entry is read, modified and written back. A sample item
// keeps busy high through states MUL1, FILT, MUL2 and TRQ: entry read, filter
// products, filter sum with write-back, torque products, torque sum and clamp.
// The next item can transfer once busy is low again. This follows from the
// registered read of the joint state memory and the two registered multiply
// stages. Output: out_valid is high for exactly one cycle per sample item,
// registered from the TRQ state, with out_item holding arm, joint, torque and
// saturated. The receiver has no way to stall; each result transfers in its
// single cycle. Configuration: cfg_we writes cfg_wdata into the filter weight;
// the user must write it only while idle; the block does not enforce this.
// Reset (rst_n low, synchronous) returns every joint to desired position zero,
// filtered velocity zero and the default gains, and sets the default weight.
module joint_impedance_torque (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  jit_pkg::in_item_t  in_item,
  output logic               out_valid,
  output jit_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_wdata
);
  import jit_pkg::*;

  ctrl_t             ctrl;
  entry_t            rd_data, wr_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  jit_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  jit_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctrl.cap),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (ctrl.wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  jit_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### sv/jit_checker.sv
`timescale 1ns / 1ps
`include "joint_impedance_torque_assert.svh"
module jit_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input jit_pkg::in_item_t  in_item,
  input logic               out_valid,
  input jit_pkg::out_item_t out_item
);
  import jit_pkg::*;

  logic good_item;
  logic take_sample;
  logic take_update;
  logic sat_out;
  logic at_limit;

  assign good_item   = (int'(in_item.arm) < ARM_COUNT) && (int'(in_item.joint) < JOINTS_PER_ARM);
  assign take_sample = start && !busy && good_item && (in_item.action == ACT_SAMPLE);
  assign take_update = start && !busy && good_item &&
                       ((in_item.action == ACT_DESIRED) || (in_item.action == ACT_GAINS));
  assign sat_out     = out_valid && out_item.saturated;
  assign at_limit    = (out_item.torque == 32'sh7fffffff) ||
                       (out_item.torque == 32'sh80000000);

  `JIT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe lasted two cycles")
  `JIT_ASSERT_NOW(a_sample_result, take_sample, ##5 out_valid, "sample transfer gave no result")
  `JIT_ASSERT_NEXT(a_update_busy, take_update, busy ##1 !busy, "update transfer busy time wrong")
  `JIT_ASSERT_NOW(a_sat_clamped, sat_out, at_limit, "saturated torque not at a limit")

endmodule

bind joint_impedance_torque jit_checker u_jit_checker (.*);
